/* rtl/life_row_generation_step_assert.svh */
// ----------------------------------------------------------------------------
// life_row_generation_step_assert.svh
// assertion macros shared by the life row generation rtl
// ----------------------------------------------------------------------------
`ifndef LIFE_ROW_GENERATION_STEP_ASSERT_SVH
`define LIFE_ROW_GENERATION_STEP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LRGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrgs assertion failed");

// next-cycle implication, disabled while reset is low
`define LRGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrgs assertion failed");

`endif

/* rtl/lrgs_pkg.sv */
// ----------------------------------------------------------------------------
// lrgs_pkg
// widths, rule constants and shared types of the life row generation block
// ----------------------------------------------------------------------------
`default_nettype none

package lrgs_pkg;

    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [SIZE_W-1:0] MIN_SIZE  = 7'd3;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 7'd64;

    // neighbor counts of the life rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // register index carried in paddr[2]
    localparam logic REG_GRID_SIZE = 1'b0;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;
    localparam int MAX_PUSH   = 3;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        t_row up;
        t_row mid;
        t_row down;
    } t_rows;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_row             cells;
        logic             done;
    } t_result;

endpackage

`default_nettype wire

/* rtl/life_row_generation_step.sv */
// ----------------------------------------------------------------------------
// life_row_generation_step
// a result is written into the result queue as its row transaction is accepted
// throughput: one row per cycle when not stalled, set by three parallel row engines
// the final row yields three results through a four-entry result queue, so the
// input stalls until at most one entry is left; rows 0 and 1 yield no result
// reset (synchronous, active low): grid_size 64, row counter and stored rows
// cleared, result queue empty; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module life_row_generation_step #(
    parameter int MAX_SIZE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrgs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lrgs_pkg::DATA_W-1:0]   pwdata,
    output logic      [lrgs_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    // row input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lrgs_pkg::ROW_W-1:0]    i_row_cells,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [lrgs_pkg::IDX_W-1:0]    o_out_row_index,
    output logic      [lrgs_pkg::ROW_W-1:0]    o_out_row_cells,
    output logic                               o_frame_done
);
    import lrgs_pkg::*;

    logic [SIZE_W-1:0] r_grid_size;
    t_row              r_first, r_second, r_older, r_newer;
    logic [SIZE_W-1:0] r_row_counter, n_row_counter;
    t_result           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [SIZE_W-1:0] w_size;
    t_row              w_mask, w_row;
    logic              w_in_acc, w_out_acc, w_cfg_wr;
    logic              w_final, w_emit;
    logic [1:0]        w_push_cnt;
    logic [PTR_W-1:0]  w_wr_ptr;
    t_rows             w_rows_a, w_rows_b, w_rows_c;
    t_row              w_next_a, w_next_b, w_next_c;
    t_result           w_push [MAX_PUSH];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GRID_SIZE);
    assign prdata   = (paddr[2] == REG_GRID_SIZE) ? DATA_W'(r_grid_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= RESET_SIZE;
        end else if (w_cfg_wr) begin
            r_grid_size <= pwdata[SIZE_W-1:0];
        end
    end

    // effective size clamped to the supported range
    always_comb begin
        if (r_grid_size < MIN_SIZE) begin
            w_size = MIN_SIZE;
        end else if (r_grid_size > SIZE_W'(MAX_SIZE)) begin
            w_size = SIZE_W'(MAX_SIZE);
        end else begin
            w_size = r_grid_size;
        end
    end

    always_comb begin
        for (int c = 0; c < ROW_W; c++) begin
            w_mask[c] = (SIZE_W'(c) < w_size);
        end
    end

    assign w_row = i_row_cells & w_mask;

    // handshakes
    assign o_in_stall  = (r_count > CNT_W'(FIFO_DEPTH - MAX_PUSH));
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign w_out_acc   = o_out_valid && !i_out_stall;

    assign w_emit  = (r_row_counter >= 7'd2);
    assign w_final = w_emit && (r_row_counter >= (w_size - 7'd1));

    // three row engines: regular row, wrapped last row, row 0
    assign w_rows_a = '{up: r_older, mid: r_newer, down: w_row};
    assign w_rows_b = '{up: r_newer, mid: w_row, down: r_first};
    assign w_rows_c = '{up: w_row, mid: r_first, down: r_second};

    lrgs_row_engine #(.MAX_SIZE(MAX_SIZE)) u_engine_a (
        .i_rows (w_rows_a), .i_size (w_size), .o_next (w_next_a)
    );
    lrgs_row_engine #(.MAX_SIZE(MAX_SIZE)) u_engine_b (
        .i_rows (w_rows_b), .i_size (w_size), .o_next (w_next_b)
    );
    lrgs_row_engine #(.MAX_SIZE(MAX_SIZE)) u_engine_c (
        .i_rows (w_rows_c), .i_size (w_size), .o_next (w_next_c)
    );

    always_comb begin
        w_push[0] = '{idx: IDX_W'(r_row_counter - 7'd1), cells: w_next_a, done: 1'b0};
        w_push[1] = '{idx: r_row_counter[IDX_W-1:0], cells: w_next_b, done: 1'b0};
        w_push[2] = '{idx: '0, cells: w_next_c, done: 1'b1};
        priority if (!w_in_acc || !w_emit) begin
            w_push_cnt = 2'd0;
        end else if (w_final) begin
            w_push_cnt = 2'd3;
        end else begin
            w_push_cnt = 2'd1;
        end
    end

    // row state
    assign n_row_counter = w_final ? '0 : r_row_counter + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first       <= '0;
            r_second      <= '0;
            r_older       <= '0;
            r_newer       <= '0;
            r_row_counter <= '0;
        end else if (w_in_acc) begin
            if (r_row_counter == 7'd0) begin
                r_first <= w_row;
            end
            if (r_row_counter == 7'd1) begin
                r_second <= w_row;
            end
            r_older       <= r_newer;
            r_newer       <= w_row;
            r_row_counter <= n_row_counter;
        end
    end

    // result queue
    assign w_wr_ptr = r_rd_ptr + r_count[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < w_push_cnt) begin
                r_fifo[PTR_W'(w_wr_ptr + PTR_W'(k))] <= w_push[k];
            end
        end
    end

    assign n_count = r_count + CNT_W'(w_push_cnt) - CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_out_acc) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_out_row_index = r_fifo[r_rd_ptr].idx;
    assign o_out_row_cells = r_fifo[r_rd_ptr].cells;
    assign o_frame_done    = r_fifo[r_rd_ptr].done;

`include "life_row_generation_step_assert.svh"

    `LRGS_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `LRGS_ASSERT_NEXT(a_final_wraps, i_clk, i_rst_n, w_in_acc && w_final, r_row_counter == 7'd0)
    `LRGS_ASSERT_NEXT(a_no_push_early, i_clk, i_rst_n, w_in_acc && !w_emit, r_count == ($past(w_out_acc) ? $past(r_count) - 3'd1 : $past(r_count)))
    `LRGS_ASSERT_NEXT(a_final_push, i_clk, i_rst_n, w_in_acc && w_final && !w_out_acc, r_count == $past(r_count) + 3'd3)

endmodule

`default_nettype wire

/* rtl/lrgs_cell.sv */
// ----------------------------------------------------------------------------
// lrgs_cell
// one lane: counts the eight neighbors of a cell and applies the life rule
// ----------------------------------------------------------------------------
`default_nettype none

module lrgs_cell (
    input  wire logic [2:0] i_up,
    input  wire logic [2:0] i_mid,
    input  wire logic [2:0] i_down,
    output logic            o_alive
);
    import lrgs_pkg::*;

    logic [3:0] w_count;

    // bit 0 left, bit 1 center, bit 2 right
    assign w_count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                   + 4'(i_mid[0]) + 4'(i_mid[2])
                   + 4'(i_down[0]) + 4'(i_down[1]) + 4'(i_down[2]);

    assign o_alive = (w_count == BIRTH_COUNT) || ((w_count == SURVIVE_COUNT) && i_mid[1]);

endmodule

`default_nettype wire

/* rtl/lrgs_row_engine.sv */
// ----------------------------------------------------------------------------
// lrgs_row_engine
// one lane per column on three rows, merged into the next-generation row
// ----------------------------------------------------------------------------
`default_nettype none

module lrgs_row_engine #(
    parameter int MAX_SIZE = 64
) (
    input  wire lrgs_pkg::t_rows            i_rows,
    input  wire logic [lrgs_pkg::SIZE_W-1:0] i_size,
    output lrgs_pkg::t_row                   o_next
);
    import lrgs_pkg::*;

    // neighbor to the left of each column, column 0 wraps to size-1
    function automatic t_row left_nb(t_row row, logic [SIZE_W-1:0] n);
        logic [IDX_W-1:0] last;
        last = IDX_W'(n - SIZE_W'(1));
        return {row[ROW_W-2:0], row[last]};
    endfunction

    // neighbor to the right of each column, column size-1 wraps to 0
    function automatic t_row right_nb(t_row row, logic [SIZE_W-1:0] n);
        t_row             res;
        logic [IDX_W-1:0] last;
        last      = IDX_W'(n - SIZE_W'(1));
        res       = {1'b0, row[ROW_W-1:1]};
        res[last] = row[0];
        return res;
    endfunction

    t_row w_up_l, w_up_r, w_mid_l, w_mid_r, w_down_l, w_down_r;
    t_row w_alive;

    assign w_up_l   = left_nb(i_rows.up, i_size);
    assign w_up_r   = right_nb(i_rows.up, i_size);
    assign w_mid_l  = left_nb(i_rows.mid, i_size);
    assign w_mid_r  = right_nb(i_rows.mid, i_size);
    assign w_down_l = left_nb(i_rows.down, i_size);
    assign w_down_r = right_nb(i_rows.down, i_size);

    for (genvar c = 0; c < ROW_W; c++) begin : g_lane
        if (c < MAX_SIZE) begin : g_on
            lrgs_cell u_cell (
                .i_up    ({w_up_r[c], i_rows.up[c], w_up_l[c]}),
                .i_mid   ({w_mid_r[c], i_rows.mid[c], w_mid_l[c]}),
                .i_down  ({w_down_r[c], i_rows.down[c], w_down_l[c]}),
                .o_alive (w_alive[c])
            );
        end else begin : g_off
            assign w_alive[c] = 1'b0;
        end
        // merge: columns at or past the size are dead
        assign o_next[c] = w_alive[c] & (SIZE_W'(c) < i_size);
    end

endmodule

`default_nettype wire

/* tb/sv/life_row_generation_step_check.sv */
// ----------------------------------------------------------------------------
// life_row_generation_step_check
// watches the config port and both row channels, predicts each next-generation
// row from its own copy of the grid state and compares every result
// transaction with the oldest prediction; hands back a failure count
// ----------------------------------------------------------------------------

module life_row_generation_step_check #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [lrgs_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [lrgs_pkg::DATA_W-1:0]   i_pwdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  lrgs_pkg::t_row                i_row_cells,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [lrgs_pkg::IDX_W-1:0]    i_out_row_index,
    input  lrgs_pkg::t_row                i_out_row_cells,
    input  logic                          i_frame_done,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lrgs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [SIZE_W-1:0] grid_size_reg = RESET_SIZE;
    t_row              gen_row0      = '0;
    t_row              gen_row1      = '0;
    t_row              gen_older     = '0;
    t_row              gen_newer     = '0;
    logic [SIZE_W-1:0] next_row_num  = '0;
    t_result           expected_rows[$];
    int                fail_count    = 0;

    assign o_fail_count = fail_count;

    // one life generation of the middle row, columns wrapping at n
    function automatic t_row life_next_row(t_row up, t_row mid, t_row down, int unsigned n);
        t_row        nxt;
        int unsigned l;
        int unsigned r;
        int unsigned cnt;
        nxt = '0;
        for (int unsigned c = 0; c < n; c++) begin
            l   = (c == 0) ? n - 1 : c - 1;
            r   = (c + 1 == n) ? 0 : c + 1;
            cnt = int'(up[l]) + int'(up[c]) + int'(up[r]) + int'(mid[l]) + int'(mid[r])
                + int'(down[l]) + int'(down[c]) + int'(down[r]);
            if (cnt == BIRTH_COUNT || (cnt == SURVIVE_COUNT && mid[c])) begin
                nxt[c] = 1'b1;
            end
        end
        return nxt;
    endfunction

    always @(posedge i_clk) begin
        int unsigned n;
        int unsigned r;
        t_row        cells;
        t_result     got;
        t_result     want;
        if (!i_rst_n) begin
            grid_size_reg = RESET_SIZE;
            gen_row0      = '0;
            gen_row1      = '0;
            gen_older     = '0;
            gen_newer     = '0;
            next_row_num  = '0;
            expected_rows.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[ADDR_W-1:2] == REG_GRID_SIZE) begin
                grid_size_reg = i_pwdata[SIZE_W-1:0];
            end

            if (i_in_valid && !i_in_stall) begin
                n = grid_size_reg;
                if (n < MIN_SIZE) n = MIN_SIZE;
                if (n > MAX_SIZE) n = MAX_SIZE;
                cells = (n >= ROW_W) ? i_row_cells : i_row_cells & ((t_row'(1) << n) - 1);
                r = next_row_num;
                if (r == 0) begin
                    gen_row0 = cells;
                end else if (r == 1) begin
                    gen_row1 = cells;
                end else begin
                    expected_rows.push_back('{idx: IDX_W'(r - 1),
                        cells: life_next_row(gen_older, gen_newer, cells, n), done: 1'b0});
                    // final row, or counter already past it after a size change
                    if (r >= n - 1) begin
                        expected_rows.push_back('{idx: IDX_W'(r),
                            cells: life_next_row(gen_newer, cells, gen_row0, n), done: 1'b0});
                        expected_rows.push_back('{idx: '0,
                            cells: life_next_row(cells, gen_row0, gen_row1, n), done: 1'b1});
                    end
                end
                gen_older = gen_newer;
                gen_newer = cells;
                if (r >= 2 && r >= n - 1) next_row_num = '0;
                else next_row_num = SIZE_W'(r + 1);
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{idx: i_out_row_index, cells: i_out_row_cells, done: i_frame_done};
                if (expected_rows.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result idx %0d cells %h done %b",
                                 $realtime, got.idx, got.cells, got.done);
                    end
                end else begin
                    want = expected_rows.pop_front();
                    if (got.idx !== want.idx || got.cells !== want.cells
                            || got.done !== want.done) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch expected %0d %h %b, got %0d %h %b",
                                     $realtime, want.idx, want.cells, want.done,
                                     got.idx, got.cells, got.done);
                        end
                    end
                end
            end
        end
        o_pending = expected_rows.size();
    end

endmodule

/* tb/sv/life_row_generation_step_test.sv */
// ----------------------------------------------------------------------------
// life_row_generation_step_test
// drives row frames at many grid sizes, with random gaps on the row channel
// and random stalls on the result channel; the checker beside the block
// predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------

module life_row_generation_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lrgs_pkg::*;

    localparam int MAX_SIZE     = 64;
    localparam int RANDOM_ITEMS = 470;
    localparam int MAX_WAIT     = 13;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [ADDR_W-1:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE     = {~REG_GRID_SIZE, 2'b00};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    t_row              in_row;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  out_idx;
    t_row              out_cells;
    logic              out_done;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          send_quiet = 1'b0;
    bit          take_quiet = 1'b0;
    int unsigned drive_size = MAX_SIZE;
    int unsigned frame_pos  = 0;
    int unsigned items_sent = 0;

    life_row_generation_step #(
        .MAX_SIZE(MAX_SIZE)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_row_cells     (in_row),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_out_row_index (out_idx),
        .o_out_row_cells (out_cells),
        .o_frame_done    (out_done)
    );

    life_row_generation_step_check #(
        .MAX_SIZE(MAX_SIZE)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_row_cells     (in_row),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_row_index (out_idx),
        .i_out_row_cells (out_cells),
        .i_frame_done    (out_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // wait per transaction, with occasional stretches of back-to-back traffic
    function automatic int unsigned pick_wait(inout bit quiet);
        if ($urandom_range(0, 23) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_row rand_row();
        t_row a;
        t_row b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return a & b;
            1: return a | b;
            2: return '0;
            3: return '1;
            4: return a & b & {$urandom, $urandom};
            default: return a;
        endcase
    endfunction

    // called and left at a falling edge
    task automatic push_row(input t_row cells);
        int unsigned gap;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_row   <= cells;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (frame_pos >= 2 && frame_pos + 1 >= drive_size) frame_pos = 0;
        else frame_pos++;
        items_sent++;
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] code);
        // upper data bits are don't-care for the register
        write_reg(ADDR_GRID_SIZE, {25'($urandom), code});
        drive_size = code;
        if (drive_size < MIN_SIZE) drive_size = MIN_SIZE;
        if (drive_size > MAX_SIZE) drive_size = MAX_SIZE;
    endtask

    // result side stall pattern
    initial begin
        int unsigned hold;
        out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            hold = pick_wait(take_quiet);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned base;
        int unsigned pick;
        int unsigned count;
        logic [SIZE_W-1:0] code;
        bit first;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_row   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // smallest grid, full and empty rows
        set_size(MIN_SIZE);
        push_row('1);
        push_row('0);
        push_row('1);
        // write to an unmapped register must leave the size alone
        write_reg(ADDR_SPARE, 32'h0000_0011);
        push_row(64'hAAAA_AAAA_AAAA_AAAA);
        push_row(64'h5555_5555_5555_5555);
        push_row('1);
        // size below the minimum, junk above the used columns
        set_size(7'd0);
        repeat (3) push_row({$urandom, $urandom} | 64'h8000_0000_0000_0000);
        // blinker
        set_size(7'd5);
        push_row('0);
        push_row(64'h4);
        push_row(64'h4);
        push_row(64'h4);
        push_row('0);
        // shrink mid-frame so the counter sits past the new last row
        set_size(7'd10);
        repeat (6) push_row(rand_row());
        set_size(7'd4);
        push_row(rand_row());
        // size above the maximum, then shrink below the counter again
        set_size(7'd127);
        repeat (3) push_row(rand_row());
        set_size(7'd2);
        push_row(rand_row());

        base  = items_sent;
        first = 1'b1;
        while (items_sent - base < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (first) begin
                set_size(RESET_SIZE);
            end else if (pick < 95) begin
                if (pick < 55) code = $urandom_range(3, 8);
                else if (pick < 72) code = $urandom_range(9, 20);
                else if (pick < 84) code = $urandom_range(0, 2);
                else if (pick < 90) code = $urandom_range(21, 63);
                else code = $urandom_range(64, 127);
                set_size(code);
            end
            // mostly finish the frame, sometimes break off part way
            if (first || $urandom_range(0, 4) != 0) begin
                count = (frame_pos + 1 >= drive_size) ? 1 : drive_size - frame_pos;
            end else begin
                count = $urandom_range(1, drive_size);
            end
            repeat (count) push_row(rand_row());
            first = 1'b0;
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
